@@ design/igfr_pkg.sv @@
package igfr_pkg;

    localparam int FRAME_LEN = 8;
    localparam int TICK_W    = 8;
    localparam int BYTE_W    = 8;
    localparam int CNT_W     = $clog2(FRAME_LEN + 1);
    localparam int IDX_W     = (FRAME_LEN > 1) ? $clog2(FRAME_LEN) : 1;
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(7);
    localparam logic [CNT_W-1:0]  FRAME_CNT     = CNT_W'(FRAME_LEN);
    localparam logic [IDX_W-1:0]  LAST_IDX      = IDX_W'(FRAME_LEN - 1);

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // closed frame: ok = full frame to emit from bank, else one discard item
    typedef struct packed {
        logic ok;
        logic bank;
    } close_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [BYTE_W-1:0] data;
    } wr_t;

    // bank handed back once its frame is fully sent
    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_SEND
    } back_state_t;

endpackage

@@ design/igfr_queue.sv @@
module igfr_queue
    import igfr_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  close_t push_data,
    input  logic   pop,
    output logic   full,
    output logic   head_valid,
    output close_t head
);

    close_t      entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push, do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/igfr_front.sv @@
module igfr_front
    import igfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [BYTE_W-1:0] s_rx_byte,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TICK_W-1:0] cfg_timeout_ticks,
    output wr_t               buf_wr,
    output logic              close_push,
    output close_t            close_data,
    input  logic              q_full,
    input  rel_t              rel
);

    logic [TICK_W-1:0] timeout_reg, timeout_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TICK_W-1:0] idle_reg, idle_next;
    logic              pending_reg, pending_next;
    logic              bank_reg, bank_next;
    logic [1:0]        busy_reg, busy_next;
    logic              accept;
    logic [TICK_W-1:0] idle_inc;
    logic              frame_full;

    assign cfg_ready  = 1'b1;
    assign s_ready    = !q_full && !busy_reg[bank_reg];
    assign accept     = s_valid && s_ready;
    assign idle_inc   = idle_reg + TICK_W'(1);
    assign frame_full = (count_reg == FRAME_CNT);

    always_comb begin
        timeout_next = timeout_reg;
        count_next   = count_reg;
        idle_next    = idle_reg;
        pending_next = pending_reg;
        bank_next    = bank_reg;
        busy_next    = busy_reg;
        buf_wr.en    = 1'b0;
        buf_wr.addr  = {bank_reg, count_reg[IDX_W-1:0]};
        buf_wr.data  = s_rx_byte;
        close_push   = 1'b0;
        close_data.ok   = frame_full;
        close_data.bank = bank_reg;

        if (cfg_valid) begin
            timeout_next = cfg_timeout_ticks;
        end
        if (rel.en) begin
            busy_next[rel.bank] = 1'b0;
        end

        if (accept) begin
            unique case (s_command)
                CMD_BYTE: begin
                    idle_next = '0;
                    if (!frame_full) begin
                        buf_wr.en    = 1'b1;
                        count_next   = count_reg + CNT_W'(1);
                        pending_next = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (pending_reg) begin
                        if (idle_inc == timeout_reg) begin
                            pending_next = 1'b0;
                            idle_next    = '0;
                            count_next   = '0;
                            close_push   = 1'b1;
                            if (frame_full) begin
                                busy_next[bank_reg] = 1'b1;
                                bank_next           = !bank_reg;
                            end
                        end else begin
                            idle_next = idle_inc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            count_reg   <= '0;
            idle_reg    <= '0;
            pending_reg <= 1'b0;
            bank_reg    <= 1'b0;
            busy_reg    <= '0;
        end else begin
            timeout_reg <= timeout_next;
            count_reg   <= count_next;
            idle_reg    <= idle_next;
            pending_reg <= pending_next;
            bank_reg    <= bank_next;
            busy_reg    <= busy_next;
        end
    end

endmodule

@@ design/igfr_back.sv @@
module igfr_back
    import igfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  wr_t               buf_wr,
    input  logic              q_valid,
    input  close_t            q_head,
    output logic              q_pop,
    output rel_t              rel,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_frame_ok,
    output logic [BYTE_W-1:0] m_data_byte,
    output logic              m_last
);

    logic [BYTE_W-1:0] mem [MEM_DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    back_state_t       state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              at_last;
    logic              done;

    assign rd_addr = {q_head.bank, idx_reg};
    assign at_last = !q_head.ok || (idx_reg == LAST_IDX);
    assign done    = (state_reg == BK_SEND) && m_ready && at_last;

    always_ff @(posedge aclk) begin
        if (buf_wr.en) begin
            mem[buf_wr.addr] <= buf_wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    idx_next   = '0;
                    state_next = q_head.ok ? BK_FETCH : BK_SEND;
                end
            end
            BK_FETCH: begin
                state_next = BK_SEND;
            end
            BK_SEND: begin
                if (m_ready) begin
                    if (at_last) begin
                        state_next = BK_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = BK_FETCH;
                    end
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        m_valid     = (state_reg == BK_SEND);
        m_frame_ok  = q_head.ok;
        m_data_byte = q_head.ok ? rd_data_reg : '0;
        m_last      = at_last;
        q_pop       = done;
        rel.en      = done && q_head.ok;
        rel.bank    = q_head.bank;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

@@ design/idle_gap_frame_receiver.sv @@
// Idle-gap frame receiver. Each input item is a received byte (command 0) or a
// timer tick (command 1). Bytes fill a frame buffer of FRAME_LEN entries; after
// timeout_ticks idle ticks following the last byte the frame closes and either
// FRAME_LEN result items (frame_ok 1, bytes in arrival order, last on the final
// one) or one discard item (frame_ok 0, data 0, last 1) come out. Input items
// are taken one per cycle; the input stalls only while two closed frames are
// still waiting to be sent, or while the buffer bank to be filled next is still
// being sent. The buffer has two banks, so one frame is sent while the next one
// is collected. Sending reads the buffer one byte at a time: each byte is a
// registered read (fetch state), then output (send state); a discard item goes
// straight to the send state. timeout_ticks is written over
// the cfg channel, which is always ready; reset value 7, and 0 means 256 ticks.
module idle_gap_frame_receiver
    import igfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_command,
    input  logic [BYTE_W-1:0] s_rx_byte,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_frame_ok,
    output logic [BYTE_W-1:0] m_data_byte,
    output logic              m_last,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [TICK_W-1:0] cfg_timeout_ticks
);

    wr_t    buf_wr;
    logic   close_push;
    close_t close_data;
    logic   q_full;
    logic   q_valid;
    close_t q_head;
    logic   q_pop;
    rel_t   rel;

    igfr_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_rx_byte         (s_rx_byte),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_timeout_ticks (cfg_timeout_ticks),
        .buf_wr            (buf_wr),
        .close_push        (close_push),
        .close_data        (close_data),
        .q_full            (q_full),
        .rel               (rel)
    );

    igfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (close_push),
        .push_data  (close_data),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head       (q_head)
    );

    igfr_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .buf_wr      (buf_wr),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .rel         (rel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_frame_ok  (m_frame_ok),
        .m_data_byte (m_data_byte),
        .m_last      (m_last)
    );

endmodule

@@ dv/igfr_checker.sv @@
module igfr_checker
    import igfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic              s_command,
    input  logic [BYTE_W-1:0] s_rx_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_frame_ok,
    input  logic [BYTE_W-1:0] m_data_byte,
    input  logic              m_last,
    input  logic              cfg_valid,
    input  logic              cfg_ready,
    input  logic [TICK_W-1:0] cfg_timeout_ticks,
    output int                err_count,
    output int                pending,
    output int                items_seen,
    output int                frames_seen,
    output int                discards_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic              ok;
        logic [BYTE_W-1:0] data;
        logic              last;
    } frame_out_t;

    frame_out_t        frame_out_due[$];

    logic [TICK_W-1:0] timeout_r;
    logic [BYTE_W-1:0] frame_mem [FRAME_LEN];
    int                held;
    logic [TICK_W-1:0] idle_cnt;
    logic              got_byte;
    logic              unsent;

    initial begin
        err_count     = 0;
        pending       = 0;
        items_seen    = 0;
        frames_seen   = 0;
        discards_seen = 0;
    end

    task automatic collect_item(input logic cmd, input logic [BYTE_W-1:0] b);
        frame_out_t r;
        if (cmd == CMD_BYTE) begin
            idle_cnt = '0;
            got_byte = 1'b1;
            if (held < FRAME_LEN) begin
                frame_mem[held] = b;
                held++;
                unsent = 1'b1;
            end
            return;
        end
        // tick: idle time only counts while stored bytes wait
        if (!(got_byte && unsent))
            return;
        idle_cnt = idle_cnt + 1'b1;
        if (idle_cnt != timeout_r)
            return;
        unsent   = 1'b0;
        idle_cnt = '0;
        if (held == FRAME_LEN) begin
            for (int i = 0; i < FRAME_LEN; i++) begin
                r.ok   = 1'b1;
                r.data = frame_mem[i];
                r.last = (i == FRAME_LEN - 1);
                frame_out_due.push_back(r);
            end
            frames_seen++;
        end else begin
            r.ok   = 1'b0;
            r.data = '0;
            r.last = 1'b1;
            frame_out_due.push_back(r);
            discards_seen++;
        end
        held = 0;
    endtask

    always @(posedge aclk) begin
        frame_out_t want;
        if (!aresetn) begin
            timeout_r = TIMEOUT_RESET;
            held      = 0;
            idle_cnt  = '0;
            got_byte  = 1'b0;
            unsent    = 1'b0;
            frame_out_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (frame_out_due.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected item ok=%0d data=%02h last=%0d", $time,
                             m_frame_ok, m_data_byte, m_last);
                end else begin
                    want = frame_out_due.pop_front();
                    if (m_frame_ok !== want.ok) begin
                        err_count++;
                        $display("%0t: frame_ok expected %0d actual %0d", $time,
                                 want.ok, m_frame_ok);
                    end
                    if (m_data_byte !== want.data) begin
                        err_count++;
                        $display("%0t: data_byte expected %02h actual %02h", $time,
                                 want.data, m_data_byte);
                    end
                    if (m_last !== want.last) begin
                        err_count++;
                        $display("%0t: last expected %0d actual %0d", $time,
                                 want.last, m_last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                timeout_r = cfg_timeout_ticks;
            if (s_valid && s_ready) begin
                items_seen++;
                collect_item(s_command, s_rx_byte);
            end
        end
        pending = frame_out_due.size();
    end

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import igfr_pkg::*;

    logic              aclk;
    logic              aresetn           = 1'b0;
    logic              s_valid           = 1'b0;
    logic              s_ready;
    logic              s_command         = CMD_BYTE;
    logic [BYTE_W-1:0] s_rx_byte         = '0;
    logic              m_valid;
    logic              m_ready           = 1'b0;
    logic              m_frame_ok;
    logic [BYTE_W-1:0] m_data_byte;
    logic              m_last;
    logic              cfg_valid         = 1'b0;
    logic              cfg_ready;
    logic [TICK_W-1:0] cfg_timeout_ticks = '0;

    int err_count, pending, items_seen, frames_seen, discards_seen;
    int sent      = 0;
    int n_cfg     = 0;
    bit s_burst   = 1'b0;
    bit m_burst   = 1'b0;
    bit hold_req  = 1'b0;

    idle_gap_frame_receiver dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_ok        (m_frame_ok),
        .m_data_byte       (m_data_byte),
        .m_last            (m_last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_timeout_ticks (cfg_timeout_ticks)
    );

    igfr_checker chk (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_rx_byte         (s_rx_byte),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_frame_ok        (m_frame_ok),
        .m_data_byte       (m_data_byte),
        .m_last            (m_last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_timeout_ticks (cfg_timeout_ticks),
        .err_count         (err_count),
        .pending           (pending),
        .items_seen        (items_seen),
        .frames_seen       (frames_seen),
        .discards_seen     (discards_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("timeout: %0d results still due", pending);
        $display("DONE: errors detected");
        $finish;
    end

    // result side: random stall per item, one long hold-off on request
    initial begin
        int stall;
        forever begin
            stall = m_burst ? 0 : $urandom_range(0, 11);
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (240) @(negedge aclk);
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // valid stays high across back-to-back items; lowered only for a gap
    task automatic send_item(input logic cmd, input logic [BYTE_W-1:0] b);
        int gap;
        gap = s_burst ? 0 : $urandom_range(0, 11);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic write_timeout(input logic [TICK_W-1:0] v);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
        cfg_timeout_ticks <= v;
        cfg_valid         <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    // n bytes, optional sub-timeout idle runs between them, then the closing ticks
    task automatic send_frame(input int n_bytes, input int to, input bit breaks);
        int ticks;
        ticks = (to == 0) ? 256 : to;
        for (int i = 0; i < n_bytes; i++) begin
            send_item(CMD_BYTE, BYTE_W'($urandom_range(0, 255)));
            if (breaks && ticks > 1 && i < n_bytes - 1 && $urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, ticks - 1))
                    send_item(CMD_TICK, BYTE_W'($urandom_range(0, 255)));
        end
        repeat (ticks) send_item(CMD_TICK, BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic random_frame(input int to);
        int kind;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
            send_frame(FRAME_LEN, to, 1'b1);
        else if (kind <= 7)
            send_frame($urandom_range(1, FRAME_LEN - 1), to, 1'b1);
        else if (kind == 8)
            send_frame($urandom_range(FRAME_LEN + 1, FRAME_LEN + 4), to, 1'b1);
        else
            repeat ($urandom_range(1, 3)) send_item(CMD_TICK, BYTE_W'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [BYTE_W-1:0] pat [9];
        int                base;
        int                to;
        pat = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'hFE, 8'h33};

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset timeout: tick before any byte, then a short frame
        send_item(CMD_TICK, 8'hFF);
        send_item(CMD_BYTE, 8'h00);
        send_item(CMD_BYTE, 8'hFF);
        send_item(CMD_BYTE, 8'h80);
        repeat (7) send_item(CMD_TICK, 8'h00);

        // full frame plus one dropped byte, then a tick with nothing pending
        write_timeout(TICK_W'(1));
        foreach (pat[i]) send_item(CMD_BYTE, pat[i]);
        send_item(CMD_TICK, 8'hA5);
        send_item(CMD_TICK, 8'h5A);

        // timeout 0 wraps to 256 idle ticks
        s_burst = 1'b1;
        write_timeout(TICK_W'(0));
        send_frame(FRAME_LEN, 0, 1'b0);
        s_burst = 1'b0;

        base = sent;
        while (sent - base < 30) begin
            case ($urandom_range(0, 3))
                0:       to = 1;
                1:       to = 2;
                default: to = $urandom_range(3, 12);
            endcase
            write_timeout(TICK_W'(to));
            s_burst = ($urandom_range(0, 3) == 0);
            m_burst = ($urandom_range(0, 3) == 0);
            repeat (2) random_frame(to);
        end
        m_burst = 1'b0;

        // long receiver hold while full frames keep coming
        write_timeout(TICK_W'(1));
        s_burst  = 1'b1;
        hold_req = 1'b1;
        repeat (3) send_frame(FRAME_LEN, 1, 1'b0);
        s_burst = 1'b0;

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);

        $display("covered %0d input items, %0d full frames, %0d discards", items_seen,
                 frames_seen, discards_seen);
        $display("timeouts 7, 1, 256 and random 1..12 over %0d writes", n_cfg);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ idle_gap_frame_receiver.f @@
design/igfr_pkg.sv
design/igfr_queue.sv
design/igfr_front.sv
design/igfr_back.sv
design/idle_gap_frame_receiver.sv
dv/igfr_checker.sv
dv/tb_top.sv
